/* hdl/triangle_element_stiffness_unit_macros.svh */
// Assertion macros shared by the triangle element stiffness unit.
// Holds only macro definitions; included by files that carry assertions.
`ifndef TRIANGLE_ELEMENT_STIFFNESS_UNIT_MACROS_SVH
`define TRIANGLE_ELEMENT_STIFFNESS_UNIT_MACROS_SVH

// Checks that a condition implies another condition in the same cycle.
`define TES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition is followed by another one a fixed number of cycles later.
`define TES_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

/* hdl/tes_pkg.sv */
// Package for the triangle element stiffness unit: widths, latencies, types.
// Depends on nothing; used by every module of the unit.
package tes_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIFF_W      = DATA_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int MAG_W       = SUM_W;
    localparam int DEN_W       = MAG_W + 1;
    localparam int PIECES      = 3;
    localparam int PIECE_W     = (MAG_W + PIECES - 1) / PIECES;
    localparam int PART_W      = DATA_WIDTH + PIECE_W;
    localparam int NUM_W       = DATA_WIDTH + PIECES * PIECE_W;
    localparam int QBITS       = DATA_WIDTH + 1;
    localparam int WIDE_W      = DEN_W + QBITS + 1;
    localparam int NUM_ENTRIES = 6;
    localparam int NUM_LANES   = NUM_ENTRIES + 1;

    localparam int GEOM_LAT  = 5;
    localparam int SCALE_LAT = 2;
    localparam int DIV_LAT   = QBITS + 2;
    localparam int TAIL_LAT  = SCALE_LAT + DIV_LAT;
    localparam int TOTAL_LAT = GEOM_LAT + TAIL_LAT;

    localparam logic [DEN_W-1:0] LOAD_DEN = DEN_W'(6) << (2 * FRAC_BITS);

    localparam int LOAD_SHIFT = 2 * FRAC_BITS + 1;
    localparam int LOAD_MW    = DATA_WIDTH + 1;
    localparam int LOAD_LO_W  = (LOAD_MW + 1) / 2;
    localparam int LOAD_HI_W  = LOAD_MW - LOAD_LO_W;
    localparam int LOAD_RSH   = LOAD_MW + 2;
    localparam int LOAD_RW    = LOAD_RSH - 1;
    localparam int LOAD_PW    = LOAD_MW + LOAD_RW;
    localparam int LOAD_PAD   = DIV_LAT - 2;

    localparam logic [LOAD_RW-1:0] LOAD_RECIP =
        LOAD_RW'(((64'd1 << LOAD_RSH) + 64'd2) / 64'd3);

    localparam int ROW_IDX [NUM_ENTRIES] = '{0, 0, 0, 1, 1, 2};
    localparam int COL_IDX [NUM_ENTRIES] = '{0, 1, 2, 1, 2, 2};

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        logic [NUM_ENTRIES-1:0][MAG_W-1:0] sum_mag;
        logic [NUM_ENTRIES-1:0]            sum_neg;
        logic [MAG_W-1:0]                  det_mag;
        logic                              det_zero;
        data_t                             conductivity;
        data_t                             source;
    } geom_out_t;

endpackage

/* hdl/triangle_element_stiffness_unit.sv */
// An accepted start flows through geometry, scaling and divider stages to done.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the one-bit dividers, 33 quotient stages per stiffness lane.
// Reset (rst_n low, asynchronous) clears the valid chain; no done strobe follows.
// Top level of the triangle element stiffness unit; depends on tes_pkg,
// tes_geom, tes_scale, tes_div, tes_load_div and the assertion macro header.
`include "triangle_element_stiffness_unit_macros.svh"

module triangle_element_stiffness_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tes_pkg::data_t first_x,
    input  tes_pkg::data_t first_y,
    input  tes_pkg::data_t second_x,
    input  tes_pkg::data_t second_y,
    input  tes_pkg::data_t third_x,
    input  tes_pkg::data_t third_y,
    input  tes_pkg::data_t conductivity,
    input  tes_pkg::data_t source,
    output logic           done,
    output tes_pkg::data_t k_aa,
    output tes_pkg::data_t k_ab,
    output tes_pkg::data_t k_ac,
    output tes_pkg::data_t k_bb,
    output tes_pkg::data_t k_bc,
    output tes_pkg::data_t k_cc,
    output tes_pkg::data_t load_share,
    output logic           degenerate
);
    import tes_pkg::*;

    geom_out_t            geom;
    data_t                lane_factor [NUM_LANES];
    logic [MAG_W-1:0]     lane_mag [NUM_LANES];
    logic                 lane_neg [NUM_LANES];
    logic [DEN_W-1:0]     lane_den [NUM_LANES];
    logic [NUM_W-1:0]     lane_num [NUM_LANES];
    logic                 lane_num_neg [NUM_LANES];
    logic [DEN_W-1:0]     lane_den_out [NUM_LANES];
    data_t                lane_quot [NUM_LANES];
    logic [TOTAL_LAT-1:0] valid_reg, valid_next;
    logic                 degen_reg [TAIL_LAT];
    data_t                res [NUM_LANES];

    assign busy = 1'b0;

    tes_geom u_geom (
        .clk          (clk),
        .first_x      (first_x),
        .first_y      (first_y),
        .second_x     (second_x),
        .second_y     (second_y),
        .third_x      (third_x),
        .third_y      (third_y),
        .conductivity (conductivity),
        .source       (source),
        .geom         (geom)
    );

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            lane_factor[k] = geom.conductivity;
            lane_mag[k]    = geom.sum_mag[k];
            lane_neg[k]    = geom.sum_neg[k];
            lane_den[k]    = {geom.det_mag, 1'b0};
        end
        lane_factor[NUM_ENTRIES] = geom.source;
        lane_mag[NUM_ENTRIES]    = geom.det_mag;
        lane_neg[NUM_ENTRIES]    = 1'b0;
        lane_den[NUM_ENTRIES]    = LOAD_DEN;
    end

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        tes_scale u_scale (
            .clk     (clk),
            .factor  (lane_factor[k]),
            .mag     (lane_mag[k]),
            .neg     (lane_neg[k]),
            .den_in  (lane_den[k]),
            .num     (lane_num[k]),
            .num_neg (lane_num_neg[k]),
            .den     (lane_den_out[k])
        );

        if (k < NUM_ENTRIES)
        begin : g_entry
            tes_div u_div (
                .clk     (clk),
                .num     (lane_num[k]),
                .num_neg (lane_num_neg[k]),
                .den     (lane_den_out[k]),
                .quot    (lane_quot[k])
            );
        end
        else
        begin : g_load
            tes_load_div u_div (
                .clk     (clk),
                .num     (lane_num[k]),
                .num_neg (lane_num_neg[k]),
                .quot    (lane_quot[k])
            );
        end
    end

    assign valid_next = {valid_reg[TOTAL_LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        degen_reg[0] <= geom.det_zero;
        for (int i = 1; i < TAIL_LAT; i++)
        begin
            degen_reg[i] <= degen_reg[i-1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            res[k] = degen_reg[TAIL_LAT-1] ? '0 : lane_quot[k];
        end
    end

    assign done       = valid_reg[TOTAL_LAT-1];
    assign degenerate = degen_reg[TAIL_LAT-1];
    assign k_aa       = res[0];
    assign k_ab       = res[1];
    assign k_ac       = res[2];
    assign k_bb       = res[3];
    assign k_bc       = res[4];
    assign k_cc       = res[5];
    assign load_share = res[6];

    `TES_ASSERT_DELAY(a_fixed_latency, clk, rst_n, start && !busy, TOTAL_LAT, done, "missing done")
    `TES_ASSERT_IMPL(a_degen_zero, clk, rst_n, done && degenerate, k_aa == 0 && k_cc == 0 && load_share == 0, "degenerate not zero")

endmodule

/* hdl/tes_geom.sv */
// Geometry pipeline: edge differences, products, determinant and entry sums.
// Five register stages; depends on tes_pkg.
module tes_geom (
    input  logic              clk,
    input  tes_pkg::data_t    first_x,
    input  tes_pkg::data_t    first_y,
    input  tes_pkg::data_t    second_x,
    input  tes_pkg::data_t    second_y,
    input  tes_pkg::data_t    third_x,
    input  tes_pkg::data_t    third_y,
    input  tes_pkg::data_t    conductivity,
    input  tes_pkg::data_t    source,
    output tes_pkg::geom_out_t geom
);
    import tes_pkg::*;

    data_t                    xy_reg [6];
    data_t                    lam_reg [4];
    data_t                    src_reg [4];
    logic signed [DIFF_W-1:0] b_next [3];
    logic signed [DIFF_W-1:0] c_next [3];
    logic signed [DIFF_W-1:0] b_reg [3];
    logic signed [DIFF_W-1:0] c_reg [3];
    logic signed [PROD_W-1:0] t1_next, t2_next, t1_reg, t2_reg;
    logic signed [PROD_W-1:0] bb_next [NUM_ENTRIES];
    logic signed [PROD_W-1:0] cc_next [NUM_ENTRIES];
    logic signed [PROD_W-1:0] bb_reg [NUM_ENTRIES];
    logic signed [PROD_W-1:0] cc_reg [NUM_ENTRIES];
    logic signed [SUM_W-1:0]  det_next, det_reg;
    logic signed [SUM_W-1:0]  sum_next [NUM_ENTRIES];
    logic signed [SUM_W-1:0]  sum_reg [NUM_ENTRIES];
    geom_out_t                geom_next, geom_reg;

    always_comb
    begin
        b_next[0] = DIFF_W'(xy_reg[3]) - DIFF_W'(xy_reg[5]);
        b_next[1] = DIFF_W'(xy_reg[5]) - DIFF_W'(xy_reg[1]);
        b_next[2] = DIFF_W'(xy_reg[1]) - DIFF_W'(xy_reg[3]);
        c_next[0] = DIFF_W'(xy_reg[4]) - DIFF_W'(xy_reg[2]);
        c_next[1] = DIFF_W'(xy_reg[0]) - DIFF_W'(xy_reg[4]);
        c_next[2] = DIFF_W'(xy_reg[2]) - DIFF_W'(xy_reg[0]);
    end

    always_comb
    begin
        t1_next = PROD_W'(c_reg[2]) * PROD_W'(b_reg[1]);
        t2_next = PROD_W'(c_reg[1]) * PROD_W'(b_reg[2]);
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            bb_next[k] = PROD_W'(b_reg[ROW_IDX[k]]) * PROD_W'(b_reg[COL_IDX[k]]);
            cc_next[k] = PROD_W'(c_reg[ROW_IDX[k]]) * PROD_W'(c_reg[COL_IDX[k]]);
        end
    end

    always_comb
    begin
        det_next = SUM_W'(t1_reg) - SUM_W'(t2_reg);
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            sum_next[k] = SUM_W'(bb_reg[k]) + SUM_W'(cc_reg[k]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            geom_next.sum_neg[k] = sum_reg[k][SUM_W-1];
            geom_next.sum_mag[k] = sum_reg[k][SUM_W-1] ? MAG_W'(-sum_reg[k])
                                                       : MAG_W'(sum_reg[k]);
        end
        geom_next.det_mag      = det_reg[SUM_W-1] ? MAG_W'(-det_reg) : MAG_W'(det_reg);
        geom_next.det_zero     = (det_reg == '0);
        geom_next.conductivity = lam_reg[3];
        geom_next.source       = src_reg[3];
    end

    always_ff @(posedge clk)
    begin
        xy_reg[0]  <= first_x;
        xy_reg[1]  <= first_y;
        xy_reg[2]  <= second_x;
        xy_reg[3]  <= second_y;
        xy_reg[4]  <= third_x;
        xy_reg[5]  <= third_y;
        lam_reg[0] <= conductivity;
        src_reg[0] <= source;
        for (int i = 1; i < 4; i++)
        begin
            lam_reg[i] <= lam_reg[i-1];
            src_reg[i] <= src_reg[i-1];
        end
        b_reg    <= b_next;
        c_reg    <= c_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        bb_reg   <= bb_next;
        cc_reg   <= cc_next;
        det_reg  <= det_next;
        sum_reg  <= sum_next;
        geom_reg <= geom_next;
    end

    assign geom = geom_reg;

endmodule

/* hdl/tes_scale.sv */
// Scaling lane: signed factor times a wide magnitude in partial products.
// Two register stages; depends on tes_pkg.
module tes_scale (
    input  logic                        clk,
    input  tes_pkg::data_t              factor,
    input  logic [tes_pkg::MAG_W-1:0]   mag,
    input  logic                        neg,
    input  logic [tes_pkg::DEN_W-1:0]   den_in,
    output logic [tes_pkg::NUM_W-1:0]   num,
    output logic                        num_neg,
    output logic [tes_pkg::DEN_W-1:0]   den
);
    import tes_pkg::*;

    logic [DATA_WIDTH-1:0]       fmag;
    logic [PIECES*PIECE_W-1:0]   mag_ext;
    logic [PART_W-1:0]           part_next [PIECES];
    logic [PART_W-1:0]           part_reg [PIECES];
    logic                        neg_next, neg_reg, neg2_reg;
    logic [DEN_W-1:0]            den_reg, den2_reg;
    logic [NUM_W-1:0]            num_next, num_reg;

    always_comb
    begin
        fmag     = factor[DATA_WIDTH-1] ? DATA_WIDTH'(-factor) : DATA_WIDTH'(factor);
        mag_ext  = (PIECES*PIECE_W)'(mag);
        neg_next = factor[DATA_WIDTH-1] ^ neg;
        for (int k = 0; k < PIECES; k++)
        begin
            part_next[k] = PART_W'(fmag) * PART_W'(mag_ext[k*PIECE_W +: PIECE_W]);
        end
    end

    always_comb
    begin
        num_next = '0;
        for (int k = 0; k < PIECES; k++)
        begin
            num_next = num_next + (NUM_W'(part_reg[k]) << (k * PIECE_W));
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        neg_reg  <= neg_next;
        den_reg  <= den_in;
        num_reg  <= num_next;
        neg2_reg <= neg_reg;
        den2_reg <= den_reg;
    end

    assign num     = num_reg;
    assign num_neg = neg2_reg;
    assign den     = den2_reg;

endmodule

/* hdl/tes_div.sv */
// Pipelined dividers with round-to-nearest and saturation: a restoring divider,
// one quotient bit per stage, and the constant divider of the load lane.
// Depends on tes_pkg.
module tes_div (
    input  logic                       clk,
    input  logic [tes_pkg::NUM_W-1:0]  num,
    input  logic                       num_neg,
    input  logic [tes_pkg::DEN_W-1:0]  den,
    output tes_pkg::data_t             quot
);
    import tes_pkg::*;

    localparam logic [QBITS:0] HALF    = (QBITS+1)'(1) << (DATA_WIDTH - 1);
    localparam logic [QBITS:0] POS_LIM = HALF - (QBITS+1)'(1);
    localparam data_t          D_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t          D_MIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [WIDE_W-1:0] rem_reg [QBITS+1];
    logic [WIDE_W-1:0] rem_next [QBITS+1];
    logic [QBITS-1:0]  q_reg [QBITS+1];
    logic [QBITS-1:0]  q_next [QBITS+1];
    logic [DEN_W-1:0]  den_reg [QBITS+1];
    logic              neg_reg [QBITS+1];
    logic              sat_reg [QBITS+1];
    logic              sat_next;
    logic [QBITS:0]    qr;
    logic              rnd;
    data_t             quot_next, quot_reg;

    always_comb
    begin
        sat_next = WIDE_W'(num) >= (WIDE_W'(den) << QBITS);
    end

    always_comb
    begin
        logic [WIDE_W-1:0] shifted;
        logic              ge;
        rem_next[0] = WIDE_W'(num);
        q_next[0]   = '0;
        for (int s = 0; s < QBITS; s++)
        begin
            shifted       = WIDE_W'(den_reg[s]) << (QBITS - 1 - s);
            ge            = rem_reg[s] >= shifted;
            rem_next[s+1] = ge ? rem_reg[s] - shifted : rem_reg[s];
            q_next[s+1]   = q_reg[s] | (QBITS'(ge) << (QBITS - 1 - s));
        end
    end

    always_comb
    begin
        rnd = (rem_reg[QBITS] << 1) >= WIDE_W'(den_reg[QBITS]);
        qr  = (QBITS+1)'(q_reg[QBITS]) + (QBITS+1)'(rnd);
        if (neg_reg[QBITS])
        begin
            if (sat_reg[QBITS] || qr > HALF)
                quot_next = D_MIN;
            else
                quot_next = DATA_WIDTH'((QBITS+1)'(0) - qr);
        end
        else
        begin
            if (sat_reg[QBITS] || qr > POS_LIM)
                quot_next = D_MAX;
            else
                quot_next = DATA_WIDTH'(qr);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_next[0];
        q_reg[0]   <= q_next[0];
        den_reg[0] <= den;
        neg_reg[0] <= num_neg;
        sat_reg[0] <= sat_next;
        for (int s = 1; s <= QBITS; s++)
        begin
            rem_reg[s] <= rem_next[s];
            q_reg[s]   <= q_next[s];
            den_reg[s] <= den_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
            sat_reg[s] <= sat_reg[s-1];
        end
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

module tes_load_div (
    input  logic                       clk,
    input  logic [tes_pkg::NUM_W-1:0]  num,
    input  logic                       num_neg,
    output tes_pkg::data_t             quot
);
    import tes_pkg::*;

    localparam logic [DATA_WIDTH-1:0] HALF  = DATA_WIDTH'(1) << (DATA_WIDTH - 1);
    localparam data_t                 D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t                 D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [NUM_W:0]               biased;
    logic                         big_next, big_reg, big2_reg;
    logic                         neg_reg, neg2_reg;
    logic [LOAD_MW-1:0]           m_next, m_reg;
    logic [LOAD_HI_W+LOAD_RW-1:0] hi_next, hi_reg;
    logic [LOAD_LO_W+LOAD_RW-1:0] lo_next, lo_reg;
    logic [LOAD_PW-1:0]           prod;
    logic [DATA_WIDTH-1:0]        q;
    data_t                        quot_next;
    data_t                        pad_reg [LOAD_PAD];

    always_comb
    begin
        biased   = (NUM_W+1)'(num) + (NUM_W+1)'(LOAD_DEN >> 1);
        big_next = |biased[NUM_W:LOAD_SHIFT+LOAD_MW];
        m_next   = biased[LOAD_SHIFT +: LOAD_MW];
    end

    always_comb
    begin
        hi_next = (LOAD_HI_W+LOAD_RW)'(m_reg[LOAD_MW-1:LOAD_LO_W])
                * (LOAD_HI_W+LOAD_RW)'(LOAD_RECIP);
        lo_next = (LOAD_LO_W+LOAD_RW)'(m_reg[LOAD_LO_W-1:0])
                * (LOAD_LO_W+LOAD_RW)'(LOAD_RECIP);
    end

    always_comb
    begin
        prod = (LOAD_PW'(hi_reg) << LOAD_LO_W) + LOAD_PW'(lo_reg);
        q    = prod[LOAD_RSH +: DATA_WIDTH];
        if (neg2_reg)
        begin
            if (big2_reg || q > HALF)
                quot_next = D_MIN;
            else
                quot_next = -q;
        end
        else
        begin
            if (big2_reg || q > HALF - DATA_WIDTH'(1))
                quot_next = D_MAX;
            else
                quot_next = q;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        big_reg    <= big_next;
        neg_reg    <= num_neg;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        big2_reg   <= big_reg;
        neg2_reg   <= neg_reg;
        pad_reg[0] <= quot_next;
        for (int i = 1; i < LOAD_PAD; i++)
        begin
            pad_reg[i] <= pad_reg[i-1];
        end
    end

    assign quot = pad_reg[LOAD_PAD-1];

endmodule
